// ===== rtl/mscc_pkg.sv =====
// Shared types and constants for the maximum segment cut counter.
`timescale 1ns / 1ps

package mscc_pkg;

    // Field widths fixed by the interface
    localparam int LEN_W = 12;
    localparam int CNT_W = 12;

    // One table entry: reachable flag plus best piece count
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/max_segment_cut_count.sv =====
// Top level: largest number of pieces for an exact cut with three lengths.
//
//  channel   | handshake       | signals
//  ----------+-----------------+-----------------------------------------------
//  request   | start / busy    | total_length, piece_a, piece_b, piece_c
//  result    | done (strobe)   | max_pieces
//
//  Each position 0..total_length of the table takes two issue slots on the
//  two read ports (three lookups back along the piece lengths need three
//  reads) and one write-back. A request with total_length >= MAX_LENGTH
//  answers 0 in the cycle after it is taken.
//  No clearing pass: every position is written before any later one reads it.
//  Reset (rst_n, async) returns the sequencer to idle; the table needs none.
//  done is high one cycle; busy is low in that cycle and a new request may be
//  taken then.
`timescale 1ns / 1ps

module max_segment_cut_count
    import mscc_pkg::*;
#(
    parameter int MAX_LENGTH = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [LEN_W-1:0] total_length,
    input  logic [LEN_W-1:0] piece_a,
    input  logic [LEN_W-1:0] piece_b,
    input  logic [LEN_W-1:0] piece_c,
    output logic             done,
    output logic [CNT_W-1:0] max_pieces
);

    localparam int AW = $clog2(MAX_LENGTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_AB,
        ST_RD_C,
        ST_WRITE
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] total_reg;
    logic [LEN_W-1:0] pa_reg, pb_reg, pc_reg;
    logic [LEN_W-1:0] pos_reg;
    entry_t           ea_reg, eb_reg;
    logic             done_reg;
    logic [CNT_W-1:0] result_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    entry_t           wr_data;
    logic [AW-1:0]    rd0_addr, rd1_addr;
    entry_t           rd0_data, rd1_data;

    logic             accept;
    logic             oversize;
    logic             use_a, use_b, use_c;
    logic [CNT_W-1:0] cand_a, cand_b, cand_c;
    entry_t           best;

    assign accept   = start && (state_reg == ST_IDLE);
    assign oversize = (32'(total_length) >= MAX_LENGTH);
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign max_pieces = result_reg;

    // Table lookups back one piece length from the current position
    always_comb
    begin
        rd0_addr = AW'(pos_reg - pa_reg);
        rd1_addr = AW'(pos_reg - pb_reg);
        if (state_reg == ST_RD_C)
        begin
            rd0_addr = AW'(pos_reg - pc_reg);
        end
    end

    // Candidate counts; a zero piece or one longer than the position is unused
    always_comb
    begin
        use_a  = (pa_reg != '0) && (pa_reg <= pos_reg) && ea_reg.valid;
        use_b  = (pb_reg != '0) && (pb_reg <= pos_reg) && eb_reg.valid;
        use_c  = (pc_reg != '0) && (pc_reg <= pos_reg) && rd0_data.valid;
        cand_a = ea_reg.count + CNT_W'(1);
        cand_b = eb_reg.count + CNT_W'(1);
        cand_c = rd0_data.count + CNT_W'(1);

        best = '0;
        if (use_a)
        begin
            best.valid = 1'b1;
            best.count = cand_a;
        end
        if (use_b && (!best.valid || cand_b > best.count))
        begin
            best.valid = 1'b1;
            best.count = cand_b;
        end
        if (use_c && (!best.valid || cand_c > best.count))
        begin
            best.valid = 1'b1;
            best.count = cand_c;
        end
        // Position zero is the start of every cut
        if (pos_reg == '0)
        begin
            best.valid = 1'b1;
            best.count = '0;
        end
    end

    assign wr_en   = (state_reg == ST_WRITE);
    assign wr_addr = AW'(pos_reg);
    assign wr_data = best;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !oversize)
                begin
                    state_next = ST_RD_AB;
                end
            end
            ST_RD_AB: state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (pos_reg == total_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD_AB;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && oversize) ||
                         ((state_reg == ST_WRITE) && (pos_reg == total_reg));
        end
    end

    // Request operands, position counter, captured entries and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            total_reg  <= total_length;
            pa_reg     <= piece_a;
            pb_reg     <= piece_b;
            pc_reg     <= piece_c;
            pos_reg    <= '0;
            result_reg <= '0;
        end
        if (state_reg == ST_RD_C)
        begin
            ea_reg <= rd0_data;
            eb_reg <= rd1_data;
        end
        if (state_reg == ST_WRITE)
        begin
            pos_reg <= pos_reg + LEN_W'(1);
            if (pos_reg == total_reg)
            begin
                result_reg <= best.valid ? best.count : '0;
            end
        end
    end

    mscc_table #(
        .DEPTH (MAX_LENGTH)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd1_addr (rd1_addr),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data)
    );

endmodule

// ===== rtl/mscc_table.sv =====
// Best-count table: one write port, two read ports, registered read data.
`timescale 1ns / 1ps

module mscc_table
    import mscc_pkg::*;
#(
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  entry_t                   wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output entry_t                   rd0_data,
    output entry_t                   rd1_data
);

    entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports, registered read data
    always_ff @(posedge clk)
    begin
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

// ===== rtl/mscc_checker.sv =====
// Port-level checker for the segment cut counter, bound to the top level.
`timescale 1ns / 1ps

module mscc_checker
    import mscc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [LEN_W-1:0] total_length,
    input logic             done,
    input logic [CNT_W-1:0] max_pieces
);

    logic [LEN_W-1:0] len_reg;

    // Length of the request in flight
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            len_reg <= total_length;
        end
    end

    // Result strobe only once the unit is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted request either starts work or answers at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request dropped");

    // Work ends only with a result
    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without result");

    // Work begins only from a request
    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without request");

    // Each piece is at least one unit long
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (max_pieces <= len_reg))
        else $error("piece count exceeds length");

endmodule

bind max_segment_cut_count mscc_checker u_mscc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .total_length (total_length),
    .done         (done),
    .max_pieces   (max_pieces)
);
